// ----- rtl/core/mkced_pkg.sv -----
// Shared types, constants and helpers for the multi-key click event detector.
// Holds the request payload structs, phase and event codes and the timer load helper.
// Depends on nothing.
package mkced_pkg;

    // Sizing
    localparam int NUM_KEYS   = 4;
    localparam int TIMER_BITS = 16;
    localparam int PIN_COUNT  = 4;
    localparam int REG_BITS   = 16;
    localparam int NUM_FLAGS  = 7;

    localparam logic [32:0] TMR_MAX_WIDE = (33'd1 << TIMER_BITS) - 33'd1;
    localparam logic [TIMER_BITS-1:0] TMR_MAX = TMR_MAX_WIDE[TIMER_BITS-1:0];

    // Register reset values
    localparam logic [REG_BITS-1:0] RST_SAMPLE_DIVIDER = 16'd20;
    localparam logic [REG_BITS-1:0] RST_DOUBLE_WINDOW  = 16'd200;
    localparam logic [REG_BITS-1:0] RST_LONG_TIME      = 16'd1000;
    localparam logic [REG_BITS-1:0] RST_REPEAT_TIME    = 16'd100;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SAMPLE_DIVIDER = 2'd0,
        REG_DOUBLE_WINDOW  = 2'd1,
        REG_LONG_TIME      = 2'd2,
        REG_REPEAT_TIME    = 2'd3
    } t_reg_index;

    // Request kinds
    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_CHECK = 1'b1
    } t_action;

    // Event flag selectors, bit positions in the flag word; EV_NONE selects no bit
    typedef enum logic [2:0] {
        EV_HOLD   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_SINGLE = 3'd3,
        EV_DOUBLE = 3'd4,
        EV_LONG   = 3'd5,
        EV_REPEAT = 3'd6,
        EV_NONE   = 3'd7
    } t_event_sel;

    // Per-key phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_PRESSED = 5'b00010,
        PH_WAIT2   = 5'b00100,
        PH_DOUBLE  = 5'b01000,
        PH_REPEAT  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       action;
        logic [3:0] pin_levels;
        logic [1:0] key_index;
        logic [2:0] event_select;
    } t_in_item;

    typedef struct packed {
        logic                 hit;
        logic [NUM_FLAGS-1:0] key_flags;
    } t_out_item;

    // Saturate a register value into the timer width
    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [REG_BITS-1:0] v);
        logic [32:0] v_wide;
        v_wide = 33'(v);
        if (v_wide > TMR_MAX_WIDE) begin
            return TMR_MAX;
        end
        return v_wide[TIMER_BITS-1:0];
    endfunction

endpackage

// ----- rtl/core/multi_key_click_event_detector.sv -----
// The result is registered: valid in the output register in the cycle after accept.
// Throughput: one request per cycle; all keys update in parallel in the accept cycle.
// A full output register that is not taken stalls intake until it drains.
// Reset (synchronous, active low) restores register defaults, clears the prescaler,
// all key phases to idle, pressed levels, timers and event flags.
// Top level of the multi-key click event detector; uses mkced_pkg.
module multi_key_click_event_detector
    import mkced_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [REG_BITS-1:0] i_cfg_data
);

    logic [REG_BITS-1:0]   r_sample_divider;
    logic [REG_BITS-1:0]   r_double_window;
    logic [REG_BITS-1:0]   r_long_time;
    logic [REG_BITS-1:0]   r_repeat_time;

    logic [15:0]           r_prescale;
    logic [15:0]           n_prescale;
    t_phase                r_phase  [NUM_KEYS];
    t_phase                n_phase  [NUM_KEYS];
    logic [NUM_KEYS-1:0]   r_now;
    logic [NUM_KEYS-1:0]   n_now;
    logic [NUM_KEYS-1:0]   r_before;
    logic [NUM_KEYS-1:0]   n_before;
    logic [TIMER_BITS-1:0] r_timer  [NUM_KEYS];
    logic [TIMER_BITS-1:0] n_timer  [NUM_KEYS];
    logic [NUM_FLAGS-1:0]  r_flags  [NUM_KEYS];
    logic [NUM_FLAGS-1:0]  n_flags  [NUM_KEYS];

    logic                  r_out_valid;
    t_out_item             r_out;
    t_out_item             n_out;

    logic                  accept;
    logic                  is_tick;
    logic                  is_check;
    logic                  do_sample;
    logic [15:0]           prescale_inc;
    logic [NUM_KEYS-1:0]   pin_pressed;

    // Accept a request whenever the output register is empty or draining
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign is_tick     = (i_in_data.action == ACT_TICK);
    assign is_check    = (i_in_data.action == ACT_CHECK);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Map pins to keys; keys beyond the pin count never read as pressed
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_pin
        if (g < PIN_COUNT) begin : g_has_pin
            assign pin_pressed[g] = !i_in_data.pin_levels[g];
        end else begin : g_no_pin
            assign pin_pressed[g] = 1'b0;
        end
    end

    // Advance the prescaler and decide whether this tick samples
    assign prescale_inc = r_prescale + 16'd1;
    assign do_sample    = is_tick && (prescale_inc >= r_sample_divider);

    always_comb begin
        n_prescale = r_prescale;
        if (is_tick) begin
            n_prescale = do_sample ? 16'd0 : prescale_inc;
        end
    end

    // Per-key timer, phase and flag update
    always_comb begin
        logic [TIMER_BITS-1:0] tmr;
        logic [NUM_FLAGS-1:0]  fl;
        logic                  now;
        logic                  sel_ok;
        sel_ok = (i_in_data.event_select != EV_NONE) && (i_in_data.event_select != EV_HOLD);
        for (int k = 0; k < NUM_KEYS; k++) begin
            n_phase[k]  = r_phase[k];
            n_now[k]    = r_now[k];
            n_before[k] = r_before[k];
            n_timer[k]  = r_timer[k];
            n_flags[k]  = r_flags[k];
            tmr = r_timer[k] - TIMER_BITS'(r_timer[k] != '0);
            fl  = r_flags[k];
            now = pin_pressed[k];
            if (is_tick) begin
                n_timer[k] = tmr;
                if (do_sample) begin
                    n_before[k] = r_now[k];
                    n_now[k]    = now;
                    fl[EV_HOLD] = now;
                    if (now && !r_now[k]) begin
                        fl[EV_DOWN] = 1'b1;
                    end
                    if (!now && r_now[k]) begin
                        fl[EV_UP] = 1'b1;
                    end
                    case (r_phase[k])
                        PH_PRESSED: begin
                            if (tmr == '0) begin
                                fl[EV_LONG] = 1'b1;
                                n_phase[k]  = PH_REPEAT;
                                n_timer[k]  = timer_load(r_repeat_time);
                            end else if (!now) begin
                                n_phase[k] = PH_WAIT2;
                                n_timer[k] = timer_load(r_double_window);
                            end
                        end
                        PH_WAIT2: begin
                            if (tmr == '0) begin
                                n_phase[k]    = PH_IDLE;
                                fl[EV_SINGLE] = 1'b1;
                            end else if (now) begin
                                fl[EV_DOUBLE] = 1'b1;
                                n_phase[k]    = PH_DOUBLE;
                            end
                        end
                        PH_DOUBLE: begin
                            if (!now) begin
                                n_phase[k] = PH_IDLE;
                            end
                        end
                        PH_REPEAT: begin
                            if (tmr == '0) begin
                                fl[EV_REPEAT] = 1'b1;
                                n_timer[k]    = timer_load(r_repeat_time);
                            end else if (!now) begin
                                n_phase[k] = PH_IDLE;
                            end
                        end
                        default: begin
                            if (now) begin
                                n_phase[k] = PH_PRESSED;
                                n_timer[k] = timer_load(r_long_time);
                            end
                        end
                    endcase
                    n_flags[k] = fl;
                end
            end else if (is_check && (32'(i_in_data.key_index) == k) && sel_ok) begin
                // Drop the checked flag; a check never clears hold
                n_flags[k][i_in_data.event_select] = 1'b0;
            end
        end
    end

    // Build the result: flags of the checked key and the selected bit
    always_comb begin
        n_out.hit       = 1'b0;
        n_out.key_flags = '0;
        if (is_check) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (32'(i_in_data.key_index) == k) begin
                    n_out.key_flags = r_flags[k];
                    if (i_in_data.event_select != EV_NONE) begin
                        n_out.hit = r_flags[k][i_in_data.event_select];
                    end
                end
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_divider <= RST_SAMPLE_DIVIDER;
            r_double_window  <= RST_DOUBLE_WINDOW;
            r_long_time      <= RST_LONG_TIME;
            r_repeat_time    <= RST_REPEAT_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SAMPLE_DIVIDER: r_sample_divider <= i_cfg_data;
                REG_DOUBLE_WINDOW:  r_double_window  <= i_cfg_data;
                REG_LONG_TIME:      r_long_time      <= i_cfg_data;
                REG_REPEAT_TIME:    r_repeat_time    <= i_cfg_data;
                default:            r_repeat_time    <= r_repeat_time;
            endcase
        end
    end

    // Commit key state on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_now      <= '0;
            r_before   <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_phase[k] <= PH_IDLE;
                r_timer[k] <= '0;
                r_flags[k] <= '0;
            end
        end else if (accept) begin
            r_prescale <= n_prescale;
            r_now      <= n_now;
            r_before   <= n_before;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_phase[k] <= n_phase[k];
                r_timer[k] <= n_timer[k];
                r_flags[k] <= n_flags[k];
            end
        end
    end

    // Output register: load on accept, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule
